### rtl/mtm_pkg.sv
// Package for the mode tracker: command and result beat types, controller
// states and status codes. No dependencies.
package mtm_pkg;

    localparam int TableEntriesDefault = 256;
    localparam int ValueBits           = 32;

    typedef enum logic [1:0] {
        FUNC_ADD   = 2'd0,
        FUNC_DROP  = 2'd1,
        FUNC_EVAL  = 2'd2,
        FUNC_CLEAR = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_ABSENT = 2'd2,
        ST_EMPTY  = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [31:0] value;
    } cmd_t;

    typedef struct packed {
        logic signed [31:0] mode_value;
        logic [31:0]        mode_count;
        logic [1:0]         status;
    } rsp_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_CLR,
        S_SCAN,
        S_SCAN_DRAIN,
        S_UPD,
        S_DONE
    } state_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load;
        logic clr_start;
        logic scan_start;
        logic upd;
        logic respond;
    } ctl_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic clr_last;
        logic scan_last;
        logic pipe_empty;
        logic is_eval;
        logic is_clear;
    } sts_t;

endpackage

### rtl/mtm_ctrl.sv
// Controller state machine of the mode tracker.
// Depends on mtm_pkg.
module mtm_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  mtm_pkg::sts_t sts,
    output mtm_pkg::ctl_t ctl
);
    import mtm_pkg::*;

    state_t state_reg, state_next;

    // State register; reset starts a clearing pass over the count memory.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        busy       = 1'b1;
        case (state_reg)
            S_INIT:
            begin
                // The clearing pass after reset gives no result beat.
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (sts.is_clear)
                begin
                    ctl.clr_start = 1'b1;
                    state_next    = S_CLR;
                end
                else
                begin
                    ctl.scan_start = 1'b1;
                    state_next     = S_SCAN_DRAIN;
                end
            end
            S_CLR:
            begin
                if (sts.clr_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_SCAN_DRAIN:
            begin
                if (sts.scan_last && sts.pipe_empty)
                begin
                    state_next = sts.is_eval ? S_DONE : S_UPD;
                end
            end
            S_UPD:
            begin
                ctl.upd    = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                ctl.respond = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### rtl/mtm_dp.sv
// Datapath of the mode tracker: slot memories, running sum and count, and a
// pipelined scan unit that matches values and ranks candidates for the mode.
// Depends on mtm_pkg.
module mtm_dp #(
    parameter int TABLE_ENTRIES = mtm_pkg::TableEntriesDefault
) (
    input  logic          clk,
    input  logic          rst_n,
    input  mtm_pkg::cmd_t cmd,
    input  mtm_pkg::ctl_t ctl,
    output mtm_pkg::sts_t sts,
    output logic          result_valid,
    output mtm_pkg::rsp_t result
);
    import mtm_pkg::*;

    localparam int VALUE_BITS = ValueBits;
    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = IW + 1;

    // Slot memories.
    logic [VALUE_BITS-1:0] val_mem [TABLE_ENTRIES];
    logic [31:0]           cnt_mem [TABLE_ENTRIES];

    // Command and accumulators.
    logic [1:0]            func_reg;
    logic [63:0]           v_reg;
    logic [63:0]           sum_reg;
    logic [31:0]           tot_reg;

    // Scan address counter and pipeline.
    logic [CW-1:0]         addr_reg;
    logic                  clr_reg, scan_reg;
    logic                  s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg;
    logic [IW-1:0]         s1_idx_reg, s2_idx_reg, s3_idx_reg, s4_idx_reg;
    logic [VALUE_BITS-1:0] s1_val_reg;
    logic [31:0]           s1_cnt_reg;
    logic [63:0]           s2_v_reg, s3_v_reg, s4_v_reg;
    logic [31:0]           s2_cnt_reg, s3_cnt_reg, s4_cnt_reg;
    logic [63:0]           s2_mag_reg, s3_mag_reg, s4_mag_reg;
    logic [63:0]           s2_plo_reg, s2_phi_reg;
    logic [127:0]          s3_diff_reg;
    logic [127:0]          s4_dist_reg;

    // Search results.
    logic                  hit_reg, free_reg;
    logic [IW-1:0]         hit_idx_reg, free_idx_reg;
    logic [31:0]           hit_cnt_reg;
    logic                  best_vld_reg;
    logic [63:0]           best_v_reg, best_mag_reg;
    logic [31:0]           best_cnt_reg;
    logic [127:0]          best_dist_reg;

    logic [63:0]           s1_v;
    logic [63:0]           s1_mag;
    logic [127:0]          prod, diff_raw;
    logic                  better;
    rsp_t                  rsp_next;

    always_comb
    begin
        s1_v   = {{(64-VALUE_BITS){s1_val_reg[VALUE_BITS-1]}}, s1_val_reg};
        s1_mag = s1_v[63] ? (~s1_v + 64'd1) : s1_v;
        // Assemble the 96-bit magnitude product from the two halves.
        prod     = {64'd0, s2_plo_reg} + {32'd0, s2_phi_reg, 32'd0};
        // For a negative value |-p - s| equals |p + s|.
        diff_raw = s2_v_reg[63] ? (prod + {{64{sum_reg[63]}}, sum_reg}) :
                                  (prod - {{64{sum_reg[63]}}, sum_reg});
        better   = !best_vld_reg || (s4_cnt_reg > best_cnt_reg) ||
                   ((s4_cnt_reg == best_cnt_reg) &&
                    ((s4_dist_reg < best_dist_reg) ||
                     ((s4_dist_reg == best_dist_reg) && (s4_mag_reg < best_mag_reg))));
    end

    // Result beat contents for the current command.
    always_comb
    begin
        rsp_next = '0;
        case (func_reg)
            FUNC_ADD:
            begin
                if (!hit_reg && !free_reg)
                begin
                    rsp_next.status = ST_FULL;
                end
            end
            FUNC_DROP:
            begin
                if (!hit_reg)
                begin
                    rsp_next.status = ST_ABSENT;
                end
            end
            FUNC_EVAL:
            begin
                if (best_vld_reg)
                begin
                    rsp_next.mode_value = 32'(signed'(best_v_reg));
                    rsp_next.mode_count = best_cnt_reg;
                end
                else
                begin
                    rsp_next.status = ST_EMPTY;
                end
            end
            default:
            begin
                rsp_next.status = ST_OK;
            end
        endcase
    end

    assign sts.clr_last   = clr_reg && (addr_reg == CW'(TABLE_ENTRIES - 1));
    assign sts.scan_last  = !scan_reg;
    assign sts.pipe_empty = !s1_vld_reg && !s2_vld_reg && !s3_vld_reg && !s4_vld_reg;
    assign sts.is_eval    = (func_reg == FUNC_EVAL);
    assign sts.is_clear   = (func_reg == FUNC_CLEAR);

    // Memory access: clear sweep, scan reads and the single update write.
    always_ff @(posedge clk)
    begin
        if (clr_reg)
        begin
            cnt_mem[addr_reg[IW-1:0]] <= 32'd0;
        end
        else if (ctl.upd && func_reg == FUNC_ADD && (hit_reg || free_reg))
        begin
            if (hit_reg)
            begin
                cnt_mem[hit_idx_reg] <= hit_cnt_reg + 32'd1;
            end
            else
            begin
                cnt_mem[free_idx_reg] <= 32'd1;
                val_mem[free_idx_reg] <= v_reg[VALUE_BITS-1:0];
            end
        end
        else if (ctl.upd && func_reg == FUNC_DROP && hit_reg)
        begin
            cnt_mem[hit_idx_reg] <= hit_cnt_reg - 32'd1;
        end
        s1_val_reg <= val_mem[addr_reg[IW-1:0]];
        s1_cnt_reg <= cnt_mem[addr_reg[IW-1:0]];
    end

    // Payload pipeline registers.
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            func_reg <= cmd.func;
            v_reg    <= {{(64-VALUE_BITS){cmd.value[VALUE_BITS-1]}},
                         cmd.value[VALUE_BITS-1:0]};
        end
        s1_idx_reg  <= addr_reg[IW-1:0];
        s2_idx_reg  <= s1_idx_reg;
        s3_idx_reg  <= s2_idx_reg;
        s4_idx_reg  <= s3_idx_reg;
        s2_v_reg    <= s1_v;
        s2_mag_reg  <= s1_mag;
        s2_cnt_reg  <= s1_cnt_reg;
        s2_plo_reg  <= {32'd0, s1_mag[31:0]} * {32'd0, tot_reg};
        s2_phi_reg  <= {32'd0, s1_mag[63:32]} * {32'd0, tot_reg};
        s3_v_reg    <= s2_v_reg;
        s3_mag_reg  <= s2_mag_reg;
        s3_cnt_reg  <= s2_cnt_reg;
        s3_diff_reg <= diff_raw;
        s4_v_reg    <= s3_v_reg;
        s4_mag_reg  <= s3_mag_reg;
        s4_cnt_reg  <= s3_cnt_reg;
        s4_dist_reg <= s3_diff_reg[127] ? (~s3_diff_reg + 128'd1) : s3_diff_reg;
    end

    // Control registers, search state and accumulators.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg     <= '0;
            clr_reg      <= 1'b1;
            scan_reg     <= 1'b0;
            s1_vld_reg   <= 1'b0;
            s2_vld_reg   <= 1'b0;
            s3_vld_reg   <= 1'b0;
            s4_vld_reg   <= 1'b0;
            sum_reg      <= '0;
            tot_reg      <= '0;
            hit_reg      <= 1'b0;
            free_reg     <= 1'b0;
            best_vld_reg <= 1'b0;
            hit_idx_reg  <= '0;
            free_idx_reg <= '0;
            hit_cnt_reg  <= '0;
            best_v_reg   <= '0;
            best_mag_reg <= '0;
            best_cnt_reg <= '0;
            best_dist_reg <= '0;
            result_valid <= 1'b0;
            result       <= '0;
        end
        else
        begin
            s1_vld_reg   <= scan_reg;
            s2_vld_reg   <= s1_vld_reg;
            s3_vld_reg   <= s2_vld_reg;
            s4_vld_reg   <= s3_vld_reg;
            // Address sweep for clear and scan.
            if (ctl.clr_start || ctl.scan_start)
            begin
                addr_reg     <= '0;
                clr_reg      <= ctl.clr_start;
                scan_reg     <= ctl.scan_start;
                hit_reg      <= 1'b0;
                free_reg     <= 1'b0;
                best_vld_reg <= 1'b0;
            end
            else if (clr_reg || scan_reg)
            begin
                if (addr_reg == CW'(TABLE_ENTRIES - 1))
                begin
                    clr_reg  <= 1'b0;
                    scan_reg <= 1'b0;
                end
                addr_reg <= addr_reg + CW'(1);
            end
            // Match, first free slot and best candidate, in index order.
            if (s4_vld_reg)
            begin
                if (s4_cnt_reg != 32'd0 && s4_v_reg == v_reg && !hit_reg)
                begin
                    hit_reg     <= 1'b1;
                    hit_idx_reg <= s4_idx_reg;
                    hit_cnt_reg <= s4_cnt_reg;
                end
                if (s4_cnt_reg == 32'd0 && !free_reg)
                begin
                    free_reg     <= 1'b1;
                    free_idx_reg <= s4_idx_reg;
                end
                if (s4_cnt_reg != 32'd0 && better)
                begin
                    best_vld_reg  <= 1'b1;
                    best_v_reg    <= s4_v_reg;
                    best_mag_reg  <= s4_mag_reg;
                    best_cnt_reg  <= s4_cnt_reg;
                    best_dist_reg <= s4_dist_reg;
                end
            end
            // Accumulator update.
            if (ctl.clr_start)
            begin
                sum_reg <= '0;
                tot_reg <= '0;
            end
            else if (ctl.upd && func_reg == FUNC_ADD && (hit_reg || free_reg))
            begin
                sum_reg <= sum_reg + v_reg;
                tot_reg <= tot_reg + 32'd1;
            end
            else if (ctl.upd && func_reg == FUNC_DROP && hit_reg)
            begin
                sum_reg <= sum_reg - v_reg;
                tot_reg <= tot_reg - 32'd1;
            end
            // Result beat.
            result_valid <= ctl.respond;
            if (ctl.respond)
            begin
                result <= rsp_next;
            end
        end
    end

endmodule

### rtl/mode_tracker_mean_tiebreak.sv
// Mode tracker with mean tie-break, top level.
// Depends on mtm_pkg, mtm_ctrl and mtm_dp.
//
// Add, drop and evaluate each take one pass over the slot memory, one slot a
// cycle, set by the single read port of the slot memories: the result beat
// follows the pass for an evaluate, and the update write for an add or drop.
// A clear command sweeps the count memory and then gives its beat. After
// reset a clearing pass runs with busy high and no beat. Each command gives
// exactly one result beat, marked by valid for one cycle; the receiver cannot
// stall it.
module mode_tracker_mean_tiebreak #(
    parameter int TABLE_ENTRIES = mtm_pkg::TableEntriesDefault
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  mtm_pkg::cmd_t cmd,
    output logic          valid,
    output mtm_pkg::rsp_t result
);
    import mtm_pkg::*;

    ctl_t ctl;
    sts_t sts;

    mtm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .ctl   (ctl)
    );

    mtm_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .ctl          (ctl),
        .sts          (sts),
        .result_valid (valid),
        .result       (result)
    );

    // A result beat only follows an accepted command.
    assert property (@(posedge clk) disable iff (!rst_n) valid |-> busy || $past(busy))
        else $error("result beat without command");

    // Once a command is taken the block reports busy.
    assert property (@(posedge clk) disable iff (!rst_n) ctl.load |=> busy)
        else $error("not busy after load");

    // An empty status carries a zero count.
    assert property (@(posedge clk) disable iff (!rst_n)
        valid && result.status == ST_EMPTY |-> result.mode_count == 32'd0)
        else $error("empty evaluate with count");

endmodule

### tb/sv/mode_tracker_mean_tiebreak_test.sv
// Self-checking testbench for mode_tracker_mean_tiebreak: drives command beats,
// predicts each result beat with a behavioral histogram and compares them.
// Depends on mtm_pkg and the mode_tracker_mean_tiebreak RTL.
`timescale 1ns / 100ps

module mode_tracker_mean_tiebreak_test;
    import mtm_pkg::*;

    localparam int Entries = 256;

    logic  clk;
    logic  rst_n;
    logic  start;
    logic  busy;
    cmd_t  cmd;
    logic  valid;
    rsp_t  result;

    mode_tracker_mean_tiebreak u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .valid  (valid),
        .result (result)
    );

    // Histogram shadow state.
    logic [31:0] hist_value [Entries];
    logic [31:0] hist_count [Entries];
    logic [63:0] hist_sum;
    logic [31:0] hist_total;

    cmd_t  pending_cmds[$];
    rsp_t  expected_rsps[$];
    int    mismatches;
    int    sender_idle_pct;

    // Exact distance |v*n - s| on 128 bits.
    function automatic logic [127:0] mean_distance(logic [31:0] v, logic [31:0] n,
                                                   logic [63:0] s);
        logic signed [127:0] prod;
        logic signed [127:0] diff;
        prod = $signed({{96{v[31]}}, v}) * $signed({96'd0, n});
        diff = prod - $signed({{64{s[63]}}, s});
        return diff[127] ? -diff : diff;
    endfunction

    function automatic logic [31:0] magnitude(logic [31:0] v);
        return v[31] ? -v : v;
    endfunction

    function automatic int find_value(logic [31:0] v);
        for (int i = 0; i < Entries; i++)
            if (hist_count[i] != 0 && hist_value[i] == v)
                return i;
        return -1;
    endfunction

    // Apply one command to the shadow histogram and return the expected beat.
    function automatic rsp_t predict_histogram(cmd_t c);
        rsp_t        r;
        int          hit;
        int          best;
        logic [127:0] bdist;
        logic [127:0] d;
        r = '0;
        hit = -1;
        best = -1;
        bdist = '0;
        case (func_t'(c.func))
            FUNC_ADD:
            begin
                hit = find_value(c.value);
                if (hit < 0)
                    for (int i = 0; i < Entries; i++)
                        if (hist_count[i] == 0)
                        begin
                            hit = i;
                            hist_value[i] = c.value;
                            break;
                        end
                if (hit < 0)
                    r.status = ST_FULL;
                else
                begin
                    hist_count[hit]++;
                    hist_sum += {{32{c.value[31]}}, c.value};
                    hist_total++;
                end
            end
            FUNC_DROP:
            begin
                hit = find_value(c.value);
                if (hit < 0)
                    r.status = ST_ABSENT;
                else
                begin
                    hist_count[hit]--;
                    hist_sum -= {{32{c.value[31]}}, c.value};
                    hist_total--;
                end
            end
            FUNC_EVAL:
            begin
                for (int i = 0; i < Entries; i++)
                begin
                    if (hist_count[i] == 0)
                        continue;
                    d = mean_distance(hist_value[i], hist_total, hist_sum);
                    if (best < 0 || hist_count[i] > hist_count[best])
                    begin
                        best = i;
                        bdist = d;
                    end
                    else if (hist_count[i] == hist_count[best] && (d < bdist ||
                             (d == bdist && magnitude(hist_value[i]) <
                              magnitude(hist_value[best]))))
                    begin
                        best = i;
                        bdist = d;
                    end
                end
                if (best < 0)
                    r.status = ST_EMPTY;
                else
                begin
                    r.mode_value = hist_value[best];
                    r.mode_count = hist_count[best];
                end
            end
            default:
            begin
                for (int i = 0; i < Entries; i++)
                    hist_count[i] = '0;
                hist_sum = '0;
                hist_total = '0;
            end
        endcase
        return r;
    endfunction

    function automatic cmd_t make_cmd(func_t f, logic [31:0] v);
        cmd_t c;
        c.func = f;
        c.value = v;
        return c;
    endfunction

    // Values mostly drawn from a small pool so adds and drops hit held entries.
    function automatic logic [31:0] pool_value(int pool);
        int k;
        k = $urandom_range(0, 3);
        if (k == 0)
            return $urandom;
        else if (k == 1)
            return $urandom_range(0, pool) - pool / 2;
        else if (k == 2)
            return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'd0} + $urandom_range(0, 3);
        return $urandom_range(0, pool);
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #80ms;
        $display("FAIL mode_tracker_mean_tiebreak");
        $finish;
    end

    // Driver: present the oldest pending beat until it is accepted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            cmd <= '0;
        end
        else if (start && !busy)
        begin
            expected_rsps.push_back(predict_histogram(cmd));
            void'(pending_cmds.pop_front());
            if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct)
                cmd <= pending_cmds[0];
            else
                start <= 1'b0;
        end
        else if (!start && pending_cmds.size() > 0 &&
                 $urandom_range(0, 99) >= sender_idle_pct)
        begin
            start <= 1'b1;
            cmd <= pending_cmds[0];
        end
    end

    // Monitor: every result beat is checked against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && valid)
        begin
            if (expected_rsps.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat %p", result);
            end
            else
            begin
                if (result !== expected_rsps[0])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", expected_rsps[0], result);
                end
                void'(expected_rsps.pop_front());
            end
        end
    end

    // Stimulus phases and end of run.
    initial
    begin
        int phase_pct[4];
        int pool;
        int r;
        phase_pct = '{0, 54, 0, 7};
        mismatches = 0;
        sender_idle_pct = 0;
        for (int i = 0; i < Entries; i++)
        begin
            hist_value[i] = '0;
            hist_count[i] = '0;
        end
        hist_sum = '0;
        hist_total = '0;

        // Directed: empty evaluate, extremes, ties, absent drop, clear.
        pending_cmds.push_back(make_cmd(FUNC_EVAL, 32'd0));
        pending_cmds.push_back(make_cmd(FUNC_DROP, 32'd5));
        pending_cmds.push_back(make_cmd(FUNC_ADD, 32'h8000_0000));
        pending_cmds.push_back(make_cmd(FUNC_ADD, 32'h7FFF_FFFF));
        pending_cmds.push_back(make_cmd(FUNC_EVAL, 32'hFFFF_FFFF));
        pending_cmds.push_back(make_cmd(FUNC_ADD, 32'hFFFF_FFFF));
        pending_cmds.push_back(make_cmd(FUNC_ADD, 32'd1));
        pending_cmds.push_back(make_cmd(FUNC_EVAL, 32'd0));
        pending_cmds.push_back(make_cmd(FUNC_DROP, 32'h8000_0000));
        pending_cmds.push_back(make_cmd(FUNC_DROP, 32'h8000_0000));
        pending_cmds.push_back(make_cmd(FUNC_ADD, 32'h7FFF_FFFF));
        pending_cmds.push_back(make_cmd(FUNC_EVAL, 32'd0));
        pending_cmds.push_back(make_cmd(FUNC_CLEAR, 32'h5555_AAAA));
        pending_cmds.push_back(make_cmd(FUNC_EVAL, 32'd0));
        // Fill the table, then overflow it and evaluate a full table.
        for (int i = 0; i < Entries; i++)
            pending_cmds.push_back(make_cmd(FUNC_ADD, i - 128));
        pending_cmds.push_back(make_cmd(FUNC_ADD, 32'd1000));
        pending_cmds.push_back(make_cmd(FUNC_ADD, 32'd3));
        pending_cmds.push_back(make_cmd(FUNC_EVAL, 32'd0));
        pending_cmds.push_back(make_cmd(FUNC_CLEAR, 32'd0));

        // Random phases with varying sender idling and value pool.
        for (int p = 0; p < 4; p++)
        begin
            wait (pending_cmds.size() == 0);
            sender_idle_pct = phase_pct[p];
            pool = (p == 2) ? 400 : 20;
            for (int n = 0; n < 232; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < 55)
                    pending_cmds.push_back(make_cmd(FUNC_ADD, pool_value(pool)));
                else if (r < 80)
                    pending_cmds.push_back(make_cmd(FUNC_DROP, pool_value(pool)));
                else if (r < 98)
                    pending_cmds.push_back(make_cmd(FUNC_EVAL, $urandom));
                else
                    pending_cmds.push_back(make_cmd(FUNC_CLEAR, $urandom));
            end
        end

        wait (pending_cmds.size() == 0 && !start);
        wait (expected_rsps.size() == 0);
        repeat (600) @(posedge clk);
        if (mismatches == 0 && expected_rsps.size() == 0)
            $display("PASS mode_tracker_mean_tiebreak");
        else
            $display("FAIL mode_tracker_mean_tiebreak");
        $finish;
    end

endmodule

### mode_tracker_mean_tiebreak.f
rtl/mtm_pkg.sv
rtl/mtm_ctrl.sv
rtl/mtm_dp.sv
rtl/mode_tracker_mean_tiebreak.sv
tb/sv/mode_tracker_mean_tiebreak_test.sv
